// ----- rtl/dtq_pkg.sv -----
// shared constants for the deadline timer queue
`timescale 1ns / 1ps

package dtq_pkg;

    localparam int DEPTH  = 16;
    localparam int IDX_W  = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int TIME_W = 32;
    localparam int OP_W   = 2;
    localparam int DLY_W  = 16;
    localparam int OUT_CNT_W = 5;

    localparam logic [OP_W-1:0] OP_TICK  = 2'd0;
    localparam logic [OP_W-1:0] OP_SET   = 2'd1;
    localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;

endpackage

// ----- rtl/deadline_timer_queue.sv -----
// deadline timer queue top level: time counter, deadline ram and scan control
// after the input transfer the op runs in exec, the ram is scanned, and done registers the result
// a new item is taken only in idle, after the scan through the deadline ram and the result are done
// the scan reads one entry a cycle and updates valid bits, counts and the minimum
// reset: synchronous active low; time, valid bits and output valid cleared
// the deadline ram is not cleared; every entry is read, but only entries marked valid count
`timescale 1ns / 1ps

module deadline_timer_queue (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  logic [dtq_pkg::OP_W-1:0]        i_operation,
    input  logic [dtq_pkg::DLY_W-1:0]       i_delay,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output logic                            o_accepted,
    output logic [dtq_pkg::OUT_CNT_W-1:0]   o_fired_count,
    output logic [dtq_pkg::OUT_CNT_W-1:0]   o_pending_count,
    output logic [dtq_pkg::DLY_W-1:0]       o_next_remaining
);

    import dtq_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_SCAN,
        ST_DONE
    } t_state;

    t_state              r_state, n_state;
    logic [OP_W-1:0]     r_op, n_op;
    logic [DLY_W-1:0]    r_delay, n_delay;
    logic [TIME_W-1:0]   r_time, n_time;
    logic [DEPTH-1:0]    r_valid, n_valid;
    logic [IDX_W-1:0]    r_free_idx, n_free_idx;
    logic                r_has_free, n_has_free;
    logic                r_free_found, n_free_found;
    logic [IDX_W-1:0]    r_idx, n_idx;
    logic                r_issue_on, n_issue_on;
    logic [IDX_W-1:0]    r_rd_idx, n_rd_idx;
    logic                r_rd_vld, n_rd_vld;
    logic                r_acc, n_acc;
    logic [CNT_W-1:0]    r_fired, n_fired;
    logic [CNT_W-1:0]    r_pending, n_pending;
    logic                r_found, n_found;
    logic [TIME_W-1:0]   r_best, n_best;
    logic                r_out_valid, n_out_valid;
    logic                r_out_acc, n_out_acc;
    logic [OUT_CNT_W-1:0] r_out_fired, n_out_fired;
    logic [OUT_CNT_W-1:0] r_out_pending, n_out_pending;
    logic [DLY_W-1:0]    r_out_rem, n_out_rem;

    logic                wr_en;
    logic [TIME_W-1:0]   wr_data;
    logic [TIME_W-1:0]   rd_data;
    logic [TIME_W-1:0]   diff;
    logic                due;
    logic                ent_valid;
    logic                fire;
    logic                keep;
    logic [DLY_W-1:0]    rem;

    dtq_ram #(
        .WIDTH (TIME_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (r_free_idx),
        .i_wr_data (wr_data),
        .i_rd_en   (r_issue_on),
        .i_rd_addr (r_idx),
        .o_rd_data (rd_data)
    );

    assign wr_en   = (r_state == ST_EXEC) && (r_op == OP_SET) && r_has_free;
    assign wr_data = r_time + {{(TIME_W-DLY_W){1'b0}}, r_delay};

    assign diff      = rd_data - r_time;
    assign due       = (diff == '0) || diff[TIME_W-1];
    assign ent_valid = r_valid[r_rd_idx];
    assign fire      = ent_valid && (r_op == OP_TICK) && due;
    assign keep      = ent_valid && !fire;

    always_comb begin
        if (!r_found || r_best[TIME_W-1]) begin
            rem = '0;
        end else if (|r_best[TIME_W-2:DLY_W]) begin
            rem = '1;
        end else begin
            rem = r_best[DLY_W-1:0];
        end
    end

    always_comb begin
        n_state       = r_state;
        n_op          = r_op;
        n_delay       = r_delay;
        n_time        = r_time;
        n_valid       = r_valid;
        n_free_idx    = r_free_idx;
        n_has_free    = r_has_free;
        n_free_found  = r_free_found;
        n_idx         = r_idx;
        n_issue_on    = r_issue_on;
        n_rd_idx      = r_rd_idx;
        n_rd_vld      = 1'b0;
        n_acc         = r_acc;
        n_fired       = r_fired;
        n_pending     = r_pending;
        n_found       = r_found;
        n_best        = r_best;
        n_out_valid   = r_out_valid && i_out_stall;
        n_out_acc     = r_out_acc;
        n_out_fired   = r_out_fired;
        n_out_pending = r_out_pending;
        n_out_rem     = r_out_rem;

        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_op    = i_operation;
                    n_delay = i_delay;
                    n_state = ST_EXEC;
                end
            end
            ST_EXEC: begin
                n_acc = 1'b0;
                case (r_op)
                    OP_TICK: begin
                        n_time = r_time + 1'b1;
                    end
                    OP_SET: begin
                        if (r_has_free) begin
                            n_valid[r_free_idx] = 1'b1;
                            n_acc = 1'b1;
                        end
                    end
                    OP_CLEAR: begin
                        n_valid = '0;
                    end
                    default: begin
                    end
                endcase
                n_idx        = '0;
                n_issue_on   = 1'b1;
                n_fired      = '0;
                n_pending    = '0;
                n_found      = 1'b0;
                n_free_found = 1'b0;
                n_state      = ST_SCAN;
            end
            ST_SCAN: begin
                if (r_issue_on) begin
                    n_rd_idx = r_idx;
                    n_rd_vld = 1'b1;
                    if (r_idx == IDX_W'(DEPTH - 1)) begin
                        n_issue_on = 1'b0;
                    end else begin
                        n_idx = r_idx + 1'b1;
                    end
                end
                if (r_rd_vld) begin
                    if (fire) begin
                        n_valid[r_rd_idx] = 1'b0;
                        n_fired = r_fired + 1'b1;
                    end
                    if (keep) begin
                        n_pending = r_pending + 1'b1;
                        if (!r_found || ($signed(diff) < $signed(r_best))) begin
                            n_found = 1'b1;
                            n_best  = diff;
                        end
                    end else if (!r_free_found) begin
                        n_free_found = 1'b1;
                        n_free_idx   = r_rd_idx;
                    end
                    if (r_rd_idx == IDX_W'(DEPTH - 1)) begin
                        n_has_free = n_free_found;
                        n_state    = ST_DONE;
                    end
                end
            end
            ST_DONE: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_out_valid   = 1'b1;
                    n_out_acc     = r_acc;
                    n_out_fired   = OUT_CNT_W'(r_fired);
                    n_out_pending = OUT_CNT_W'(r_pending);
                    n_out_rem     = rem;
                    n_state       = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_time       <= '0;
            r_valid      <= '0;
            r_free_idx   <= '0;
            r_has_free   <= 1'b1;
            r_free_found <= 1'b0;
            r_idx        <= '0;
            r_issue_on   <= 1'b0;
            r_rd_idx     <= '0;
            r_rd_vld     <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_time       <= n_time;
            r_valid      <= n_valid;
            r_free_idx   <= n_free_idx;
            r_has_free   <= n_has_free;
            r_free_found <= n_free_found;
            r_idx        <= n_idx;
            r_issue_on   <= n_issue_on;
            r_rd_idx     <= n_rd_idx;
            r_rd_vld     <= n_rd_vld;
            r_out_valid  <= n_out_valid;
        end
        r_op          <= n_op;
        r_delay       <= n_delay;
        r_acc         <= n_acc;
        r_fired       <= n_fired;
        r_pending     <= n_pending;
        r_found       <= n_found;
        r_best        <= n_best;
        r_out_acc     <= n_out_acc;
        r_out_fired   <= n_out_fired;
        r_out_pending <= n_out_pending;
        r_out_rem     <= n_out_rem;
    end

    assign o_in_stall       = (r_state != ST_IDLE);
    assign o_out_valid      = r_out_valid;
    assign o_accepted       = r_out_acc;
    assign o_fired_count    = r_out_fired;
    assign o_pending_count  = r_out_pending;
    assign o_next_remaining = r_out_rem;

endmodule

// ----- rtl/dtq_ram.sv -----
// generic single-write, single-read ram with registered read data
`timescale 1ns / 1ps

module dtq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ----- dv/deadline_timer_queue_tb.sv -----
// testbench for the deadline timer queue: directed table, random timer traffic, scoreboard
`timescale 1ns / 1ps

module deadline_timer_queue_tb;

    import dtq_pkg::*;

    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int PHASE_ITEMS = 425;
    localparam int MAX_GAP = 30;

    typedef struct packed {
        logic                 accepted;
        logic [OUT_CNT_W-1:0] fired_count;
        logic [OUT_CNT_W-1:0] pending_count;
        logic [DLY_W-1:0]     next_remaining;
    } t_alarm_report;

    typedef struct packed {
        logic [OP_W-1:0]  op;
        logic [DLY_W-1:0] delay;
        logic [4:0]       reps;
        logic             typed;
        t_alarm_report    report;
    } t_directed_row;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_in_valid;
    logic                 o_in_stall;
    logic [OP_W-1:0]      i_operation;
    logic [DLY_W-1:0]     i_delay;
    logic                 o_out_valid;
    logic                 i_out_stall;
    logic                 o_accepted;
    logic [OUT_CNT_W-1:0] o_fired_count;
    logic [OUT_CNT_W-1:0] o_pending_count;
    logic [DLY_W-1:0]     o_next_remaining;

    // timer table copy used to predict reports; typed directed rows give their own
    logic [TIME_W-1:0] tbl_now;
    logic [TIME_W-1:0] tbl_deadline [DEPTH];
    logic              tbl_live [DEPTH];

    t_alarm_report alarm_reports_q [$];
    t_alarm_report oldest_report;

    int unsigned sender_idle_pct;
    int unsigned rx_stall_pct;
    int unsigned cycle_count;
    int unsigned mismatch_count;
    int unsigned items_sent;
    int unsigned timers_fired;
    int unsigned sets_refused;
    int unsigned clears_sent;
    int unsigned reports_seen;

    t_directed_row directed_rows [12] = '{
        '{OP_TICK,   16'hFFFF, 5'd1,  1'b1, '{1'b0, 5'd0, 5'd0,  16'd0}},
        '{OP_UNUSED, 16'hFFFF, 5'd1,  1'b1, '{1'b0, 5'd0, 5'd0,  16'd0}},
        '{OP_CLEAR,  16'hFFFF, 5'd1,  1'b1, '{1'b0, 5'd0, 5'd0,  16'd0}},
        '{OP_SET,    16'h0000, 5'd1,  1'b1, '{1'b1, 5'd0, 5'd1,  16'd0}},
        '{OP_TICK,   16'h0000, 5'd1,  1'b1, '{1'b0, 5'd1, 5'd0,  16'd0}},
        '{OP_SET,    16'hFFFF, 5'd1,  1'b1, '{1'b1, 5'd0, 5'd1,  16'hFFFF}},
        '{OP_SET,    16'h0001, 5'd15, 1'b0, '{1'b0, 5'd0, 5'd0,  16'd0}},
        '{OP_SET,    16'h5555, 5'd1,  1'b1, '{1'b0, 5'd0, 5'd16, 16'd1}},
        '{OP_TICK,   16'hAAAA, 5'd1,  1'b0, '{1'b0, 5'd0, 5'd0,  16'd0}},
        '{OP_CLEAR,  16'h0000, 5'd1,  1'b1, '{1'b0, 5'd0, 5'd0,  16'd0}},
        '{OP_SET,    16'hAAAA, 5'd1,  1'b0, '{1'b0, 5'd0, 5'd0,  16'd0}},
        '{OP_UNUSED, 16'h5555, 5'd1,  1'b0, '{1'b0, 5'd0, 5'd0,  16'd0}}
    };

    deadline_timer_queue u_top (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_operation      (i_operation),
        .i_delay          (i_delay),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_accepted       (o_accepted),
        .o_fired_count    (o_fired_count),
        .o_pending_count  (o_pending_count),
        .o_next_remaining (o_next_remaining)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic t_alarm_report step_timer_table(input logic [OP_W-1:0] op,
                                                       input logic [DLY_W-1:0] delay);
        t_alarm_report rpt;
        logic [TIME_W-1:0] diff;
        logic [TIME_W-1:0] key;
        logic [TIME_W-1:0] best_key;
        logic [TIME_W-1:0] best_diff;
        logic found;
        logic placed;
        int fired;
        int live_count;
        rpt = '0;
        found = 1'b0;
        placed = 1'b0;
        best_key = '0;
        best_diff = '0;
        fired = 0;
        live_count = 0;
        case (op)
            OP_TICK: begin
                tbl_now = tbl_now + 1;
                for (int i = 0; i < DEPTH; i++) begin
                    diff = tbl_deadline[i] - tbl_now;
                    if (tbl_live[i] && (diff == '0 || diff[TIME_W-1])) begin
                        tbl_live[i] = 1'b0;
                        fired++;
                    end
                end
            end
            OP_SET: begin
                for (int i = 0; i < DEPTH; i++) begin
                    if (!placed && !tbl_live[i]) begin
                        tbl_deadline[i] = tbl_now + TIME_W'(delay);
                        tbl_live[i] = 1'b1;
                        placed = 1'b1;
                    end
                end
                rpt.accepted = placed;
            end
            OP_CLEAR: begin
                for (int i = 0; i < DEPTH; i++) tbl_live[i] = 1'b0;
            end
            default: ;
        endcase
        // earliest deadline by signed difference from now
        for (int i = 0; i < DEPTH; i++) begin
            if (tbl_live[i]) begin
                live_count++;
                diff = tbl_deadline[i] - tbl_now;
                key = diff ^ 32'h8000_0000;
                if (!found || key < best_key) begin
                    found = 1'b1;
                    best_key = key;
                    best_diff = diff;
                end
            end
        end
        rpt.fired_count = fired[OUT_CNT_W-1:0];
        rpt.pending_count = live_count[OUT_CNT_W-1:0];
        if (!found || best_diff[TIME_W-1])
            rpt.next_remaining = '0;
        else if (best_diff > 32'h0000_FFFF)
            rpt.next_remaining = '1;
        else
            rpt.next_remaining = best_diff[DLY_W-1:0];
        return rpt;
    endfunction

    function automatic logic [DLY_W-1:0] pick_delay();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 70)
            return DLY_W'($urandom_range(24));
        else if (r < 85)
            return DLY_W'($urandom_range(255));
        return DLY_W'($urandom_range(65535));
    endfunction

    task automatic send_item(input logic [OP_W-1:0] op, input logic [DLY_W-1:0] delay,
                             input logic typed, input t_alarm_report typed_report);
        t_alarm_report predicted;
        int unsigned gap;
        i_in_valid <= 1'b1;
        i_operation <= op;
        i_delay <= delay;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        predicted = step_timer_table(op, delay);
        alarm_reports_q.push_back(typed ? typed_report : predicted);
        if (op != OP_UNUSED) items_sent++;
        if (op == OP_CLEAR) clears_sent++;
        if (op == OP_SET && !predicted.accepted) sets_refused++;
        timers_fired += predicted.fired_count;
        gap = 0;
        if (sender_idle_pct != 0 && $urandom_range(99) < sender_idle_pct)
            gap = $urandom_range(MAX_GAP, 1);
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic drain_reports();
        i_in_valid <= 1'b0;
        while (alarm_reports_q.size() != 0) @(posedge i_clk);
    endtask

    task automatic run_timer_traffic(input int unsigned item_goal);
        int unsigned goal;
        int unsigned kind;
        int unsigned len;
        int unsigned r;
        logic [OP_W-1:0] op;
        goal = items_sent + item_goal;
        while (items_sent < goal) begin
            kind = $urandom_range(99);
            if (kind < 65) begin
                // ordinary mix of set and tick with the odd clear or unused op
                len = $urandom_range(24, 8);
                repeat (len) begin
                    r = $urandom_range(99);
                    op = (r < 50) ? OP_TICK : (r < 92) ? OP_SET :
                         (r < 97) ? OP_CLEAR : OP_UNUSED;
                    send_item(op, pick_delay(), 1'b0, '0);
                end
            end else if (kind < 82) begin
                // fill the table to full or past it, then let time run
                len = $urandom_range(20, 16);
                repeat (len) send_item(OP_SET, pick_delay(), 1'b0, '0);
                len = $urandom_range(12, 1);
                repeat (len) send_item(OP_TICK, DLY_W'($urandom_range(65535)), 1'b0, '0);
            end else begin
                len = $urandom_range(12, 4);
                repeat (len)
                    send_item(OP_W'($urandom_range(3)), DLY_W'($urandom_range(65535)),
                              1'b0, '0);
            end
        end
    endtask

    task automatic check_field(input string field, input int unsigned want,
                               input int unsigned got);
        if (want != got) begin
            mismatch_count++;
            $display("%0t mismatch %s expected %0d actual %0d", $time, field, want, got);
        end
    endtask

    always @(posedge i_clk) begin
        i_out_stall <= ($urandom_range(99) < rx_stall_pct);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            reports_seen++;
            if (alarm_reports_q.size() == 0) begin
                mismatch_count++;
                $display("%0t unexpected report accepted=%0d fired=%0d pending=%0d next=%0d",
                         $time, o_accepted, o_fired_count, o_pending_count,
                         o_next_remaining);
            end else begin
                oldest_report = alarm_reports_q.pop_front();
                check_field("accepted", oldest_report.accepted, o_accepted);
                check_field("fired_count", oldest_report.fired_count, o_fired_count);
                check_field("pending_count", oldest_report.pending_count, o_pending_count);
                check_field("next_remaining", oldest_report.next_remaining,
                            o_next_remaining);
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("%0t timeout with %0d reports outstanding", $time,
                     alarm_reports_q.size());
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial begin
        i_rst_n <= 1'b0;
        i_in_valid <= 1'b0;
        i_operation <= OP_TICK;
        i_delay <= '0;
        i_out_stall <= 1'b0;
        sender_idle_pct = 0;
        rx_stall_pct = 0;
        cycle_count = 0;
        mismatch_count = 0;
        items_sent = 0;
        timers_fired = 0;
        sets_refused = 0;
        clears_sent = 0;
        reports_seen = 0;
        tbl_now = '0;
        for (int i = 0; i < DEPTH; i++) begin
            tbl_live[i] = 1'b0;
            tbl_deadline[i] = '0;
        end
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_rows[n]) begin
            repeat (directed_rows[n].reps)
                send_item(directed_rows[n].op, directed_rows[n].delay,
                          directed_rows[n].typed, directed_rows[n].report);
        end
        drain_reports();

        sender_idle_pct = 0;
        rx_stall_pct = 0;
        run_timer_traffic(PHASE_ITEMS);
        drain_reports();

        sender_idle_pct = 75;
        rx_stall_pct = 0;
        run_timer_traffic(PHASE_ITEMS);
        drain_reports();

        sender_idle_pct = 0;
        rx_stall_pct = 75;
        run_timer_traffic(PHASE_ITEMS);
        drain_reports();

        sender_idle_pct = 6;
        rx_stall_pct = 6;
        run_timer_traffic(PHASE_ITEMS);
        drain_reports();

        repeat (DEPTH + 8) @(posedge i_clk);

        $display("%0d timer operations, %0d reports checked over %0d cycles", items_sent,
                 reports_seen, cycle_count);
        $display("%0d timers fired, %0d sets refused on a full table, %0d clears",
                 timers_fired, sets_refused, clears_sent);
        if (mismatch_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
